/* rtl/cht_pkg.sv */
// Package: shared types, codes and defaults of the chained hash table.
`default_nettype none
package cht_pkg;

  localparam int unsigned BUCKETS_DEF    = 256;
  localparam int unsigned NODES_DEF      = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned KEY_W          = 64;
  localparam int unsigned CNT_W          = 9;   // bucket_count register width
  localparam logic [CNT_W-1:0] CNT_RESET = 9'd256;

  typedef enum logic [2:0] {
    ACT_FIND    = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_REPLACE = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_CLEAR   = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NOTFOUND = 2'd1,
    STS_FULL     = 2'd2
  } sts_e;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_MOD, ST_HEAD, ST_NODE,
    ST_FREE, ST_ALLOC, ST_POP, ST_INS, ST_DONE
  } state_e;

  // Result of the modulo unit.
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_res_t;

endpackage
`default_nettype wire

/* rtl/cht_mod.sv */
// Modulo unit: floored remainder of a signed 64-bit key, 8 quotient bits per cycle.
`default_nettype none
module cht_mod (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [cht_pkg::KEY_W-1:0]     key_i,
  input  wire logic [cht_pkg::CNT_W-1:0]     div_i,   // 1..256
  output cht_pkg::mod_res_t                  res_o
);
  localparam int unsigned RW = cht_pkg::CNT_W;

  logic [cht_pkg::KEY_W-1:0] mag_q, mag_d;
  logic [RW-1:0]             rem_q, rem_d, div_q, div_d;
  logic                      neg_q, neg_d;
  logic [2:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic [RW:0]               r;

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    div_d  = div_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    r      = '0;
    if (start_i) begin
      neg_d  = key_i[cht_pkg::KEY_W-1];
      mag_d  = neg_d ? (~key_i + 64'd1) : key_i;
      rem_d  = '0;
      div_d  = div_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      r = {1'b0, rem_q};
      for (int i = 0; i < 8; i++) begin
        r = {r[RW-1:0], mag_q[cht_pkg::KEY_W-1-i]};
        if (r >= {1'b0, div_q}) r = r - {1'b0, div_q};
      end
      rem_d = r[RW-1:0];
      mag_d = {mag_q[cht_pkg::KEY_W-9:0], 8'd0};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  // Negative keys: fold the magnitude remainder back to a non-negative one.
  assign res_o.done = done_q;
  assign res_o.rem  = (neg_q && rem_q != '0) ? (div_q - rem_q) : rem_q;

endmodule
`default_nettype wire

/* rtl/chained_hash_table_int64.sv */
// Top level: chained hash table with signed 64-bit keys and a node pool.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | input     | in_valid_i/in_ready_o | action_i, key_i, value_i
//  out     | output    | out_valid_o/out_ready_i | found_o, data_o, status_o, entry_count_o
//  cfg     | input     | cfg_we_i (no wait)    | cfg_wdata_i -> bucket_count
//
//  One transaction at a time. The modulo unit reduces the key (8 key bits per
//  cycle), the bucket head is read and the chain is walked one node at a time;
//  an unlinked node goes on the free list; inserts pop it or bump the mark.
//  Reset and clear sweep the bucket memory, one entry per cycle; no transaction
//  is accepted during the sweep after reset.
//  The result sits in an output register; a new transaction is taken while it
//  waits, and the block stalls only when the next result is ready.
`default_nettype none
module chained_hash_table_int64 #(
  parameter int unsigned BUCKETS    = cht_pkg::BUCKETS_DEF,
  parameter int unsigned NODES      = cht_pkg::NODES_DEF,
  parameter int unsigned DATA_WIDTH = cht_pkg::DATA_WIDTH_DEF,
  localparam int unsigned NW = $clog2(NODES + 1)   // node index incl. null
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cht_pkg::CNT_W-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [2:0]                    action_i,
  input  wire logic signed [63:0]            key_i,
  input  wire logic [31:0]                   value_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          found_o,
  output      logic [31:0]                   data_o,
  output      logic [1:0]                    status_o,
  output      logic [NW-1:0]                 entry_count_o
);
  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned KW  = cht_pkg::KEY_W;
  localparam int unsigned BA  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NA  = $clog2(NODES);
  localparam int unsigned NDW = KW + DW + NW;
  localparam logic [NW-1:0] NIL = NW'(NODES);

  cht_pkg::state_e state_q, state_d;

  // bucket_count register, clamped to 1..BUCKETS for hashing
  logic [cht_pkg::CNT_W-1:0] cfg_q, div;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_q <= cht_pkg::CNT_RESET;
    else if (cfg_we_i) cfg_q <= cfg_wdata_i;
  end
  always_comb begin
    div = (cfg_q == '0) ? cht_pkg::CNT_W'(1) : cfg_q;
    if (32'(div) > 32'(BUCKETS)) div = cht_pkg::CNT_W'(BUCKETS);
  end

  // Transaction registers
  logic [2:0]     act_q, act_d;
  logic [KW-1:0]  key_q, key_d;
  logic [DW-1:0]  val_q, val_d;
  logic [BA-1:0]  bkt_q, bkt_d;
  logic [NW-1:0]  head_q, head_d, cur_q, cur_d, prev_q, prev_d, alloc_q, alloc_d;
  logic [KW-1:0]  pkey_q, pkey_d;
  logic [DW-1:0]  pval_q, pval_d;
  logic           res_found_q, res_found_d;
  logic [DW-1:0]  res_data_q, res_data_d;
  logic [1:0]     res_sts_q, res_sts_d;
  // Control registers
  logic [NW-1:0]  free_q, free_d, mark_q, mark_d, count_q, count_d;
  logic [BA-1:0]  sweep_q, sweep_d;
  logic           clr_pend_q, clr_pend_d;
  logic           out_valid_q, out_valid_d;
  logic           found_q, found_d;
  logic [31:0]    data_q, data_d;
  logic [1:0]     status_q, status_d;
  logic [NW-1:0]  ecount_q, ecount_d;

  logic in_acc;
  assign in_ready_o = (state_q == cht_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Modulo unit
  logic              mod_start;
  cht_pkg::mod_res_t mod_res;
  assign mod_start = in_acc && (action_i <= 3'(cht_pkg::ACT_REMOVE));

  cht_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (key_i),
    .div_i   (div),
    .res_o   (mod_res)
  );

  // Bucket head memory
  logic [NW-1:0] bh_mem [BUCKETS];
  logic          bh_we, bh_re;
  logic [BA-1:0] bh_waddr, bh_raddr;
  logic [NW-1:0] bh_wdata, bh_rdata_q;
  always_ff @(posedge clk_i) begin
    if (bh_we) bh_mem[bh_waddr] <= bh_wdata;
    if (bh_re) bh_rdata_q <= bh_mem[bh_raddr];
  end

  // Node memory: {key, data, link}
  logic [NDW-1:0] nd_mem [NODES];
  logic           nd_we, nd_re;
  logic [NA-1:0]  nd_waddr, nd_raddr;
  logic [NDW-1:0] nd_wdata, nd_rdata_q;
  always_ff @(posedge clk_i) begin
    if (nd_we) nd_mem[nd_waddr] <= nd_wdata;
    if (nd_re) nd_rdata_q <= nd_mem[nd_raddr];
  end

  logic [KW-1:0] r_key;
  logic [DW-1:0] r_val, want;
  logic [NW-1:0] r_link;
  logic          key_hit, hit, link_end, head_nil;
  assign r_key    = nd_rdata_q[NDW-1 -: KW];
  assign r_val    = nd_rdata_q[NW+DW-1 -: DW];
  assign r_link   = nd_rdata_q[NW-1:0];
  assign want     = (act_q == cht_pkg::ACT_REMOVE) ? val_q : '0;
  assign key_hit  = (r_key == key_q);
  assign hit      = key_hit && (act_q == cht_pkg::ACT_FIND || want == '0 || r_val == want);
  assign link_end = (r_link >= NIL);
  assign head_nil = (bh_rdata_q >= NIL);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cht_pkg::ST_INIT:
        if (sweep_q == BA'(BUCKETS - 1)) state_d = clr_pend_q ? cht_pkg::ST_DONE
                                                             : cht_pkg::ST_IDLE;
      cht_pkg::ST_IDLE:
        if (in_acc) begin
          if (mod_start)                              state_d = cht_pkg::ST_MOD;
          else if (action_i == 3'(cht_pkg::ACT_CLEAR)) state_d = cht_pkg::ST_INIT;
          else                                        state_d = cht_pkg::ST_DONE;
        end
      cht_pkg::ST_MOD:
        if (mod_res.done) state_d = cht_pkg::ST_HEAD;
      cht_pkg::ST_HEAD:
        case (act_q)
          cht_pkg::ACT_FIND:
            state_d = head_nil ? cht_pkg::ST_DONE : cht_pkg::ST_NODE;
          cht_pkg::ACT_REPLACE:
            state_d = (!head_nil && count_q != '0) ? cht_pkg::ST_NODE : cht_pkg::ST_ALLOC;
          cht_pkg::ACT_REMOVE:
            state_d = (head_nil || count_q == '0) ? cht_pkg::ST_DONE : cht_pkg::ST_NODE;
          default:
            state_d = cht_pkg::ST_ALLOC;
        endcase
      cht_pkg::ST_NODE:
        if (hit) begin
          state_d = (act_q == cht_pkg::ACT_FIND) ? cht_pkg::ST_DONE : cht_pkg::ST_FREE;
        end else if (link_end) begin
          state_d = (act_q == cht_pkg::ACT_REPLACE) ? cht_pkg::ST_ALLOC : cht_pkg::ST_DONE;
        end
      cht_pkg::ST_FREE:
        state_d = (act_q == cht_pkg::ACT_REPLACE) ? cht_pkg::ST_ALLOC : cht_pkg::ST_DONE;
      cht_pkg::ST_ALLOC:
        if (free_q != NIL)       state_d = cht_pkg::ST_POP;
        else if (mark_q < NIL)   state_d = cht_pkg::ST_INS;
        else                     state_d = cht_pkg::ST_DONE;
      cht_pkg::ST_POP:  state_d = cht_pkg::ST_INS;
      cht_pkg::ST_INS:  state_d = cht_pkg::ST_DONE;
      cht_pkg::ST_DONE:
        if (!out_valid_q || out_ready_i) state_d = cht_pkg::ST_IDLE;
      default: state_d = cht_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    act_d = act_q;  key_d = key_q;  val_d = val_q;  bkt_d = bkt_q;
    head_d = head_q; cur_d = cur_q; prev_d = prev_q; alloc_d = alloc_q;
    pkey_d = pkey_q; pval_d = pval_q;
    res_found_d = res_found_q; res_data_d = res_data_q; res_sts_d = res_sts_q;
    free_d = free_q; mark_d = mark_q; count_d = count_q;
    sweep_d = sweep_q; clr_pend_d = clr_pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d = found_q; data_d = data_q; status_d = status_q; ecount_d = ecount_q;
    bh_we = 1'b0; bh_waddr = bkt_q; bh_wdata = NIL;
    bh_re = 1'b0; bh_raddr = BA'(mod_res.rem);
    nd_we = 1'b0; nd_waddr = cur_q[NA-1:0]; nd_wdata = {key_q, val_q, head_q};
    nd_re = 1'b0; nd_raddr = cur_q[NA-1:0];

    case (state_q)
      cht_pkg::ST_INIT: begin
        bh_we    = 1'b1;
        bh_waddr = sweep_q;
        bh_wdata = NIL;
        sweep_d  = sweep_q + BA'(1);
        if (sweep_q == BA'(BUCKETS - 1)) sweep_d = '0;
      end
      cht_pkg::ST_IDLE:
        if (in_acc) begin
          act_d       = action_i;
          key_d       = key_i;
          val_d       = DW'(value_i);
          res_found_d = 1'b0;
          res_data_d  = '0;
          res_sts_d   = cht_pkg::STS_OK;
          if (action_i == 3'(cht_pkg::ACT_CLEAR)) begin
            free_d     = NIL;
            mark_d     = '0;
            count_d    = '0;
            clr_pend_d = 1'b1;
          end
        end
      cht_pkg::ST_MOD:
        if (mod_res.done) begin
          bkt_d = BA'(mod_res.rem);
          bh_re = 1'b1;
        end
      cht_pkg::ST_HEAD: begin
        head_d = bh_rdata_q;
        cur_d  = bh_rdata_q;
        prev_d = NIL;
        nd_re  = 1'b1;
        nd_raddr = bh_rdata_q[NA-1:0];
        if ((act_q == cht_pkg::ACT_FIND && head_nil) ||
            (act_q == cht_pkg::ACT_REMOVE && (head_nil || count_q == '0))) begin
          res_sts_d = cht_pkg::STS_NOTFOUND;
        end
      end
      cht_pkg::ST_NODE:
        if (hit) begin
          if (act_q == cht_pkg::ACT_FIND) begin
            res_found_d = 1'b1;
            res_data_d  = r_val;
          end else begin
            // unlink from predecessor or bucket head
            if (prev_q == NIL) begin
              bh_we    = 1'b1;
              bh_wdata = r_link;
              head_d   = r_link;
            end else begin
              nd_we    = 1'b1;
              nd_waddr = prev_q[NA-1:0];
              nd_wdata = {pkey_q, pval_q, r_link};
            end
            pkey_d = r_key;
            pval_d = r_val;
          end
        end else if (link_end) begin
          if (act_q != cht_pkg::ACT_REPLACE) res_sts_d = cht_pkg::STS_NOTFOUND;
        end else begin
          prev_d   = cur_q;
          pkey_d   = r_key;
          pval_d   = r_val;
          cur_d    = r_link;
          nd_re    = 1'b1;
          nd_raddr = r_link[NA-1:0];
        end
      cht_pkg::ST_FREE: begin
        // push the unlinked node on the free list
        nd_we    = 1'b1;
        nd_waddr = cur_q[NA-1:0];
        nd_wdata = {pkey_q, pval_q, free_q};
        free_d   = cur_q;
        count_d  = count_q - NW'(1);
        if (act_q == cht_pkg::ACT_REMOVE) begin
          res_found_d = 1'b1;
          res_data_d  = pval_q;
        end
      end
      cht_pkg::ST_ALLOC:
        if (free_q != NIL) begin
          alloc_d  = free_q;
          nd_re    = 1'b1;
          nd_raddr = free_q[NA-1:0];
        end else if (mark_q < NIL) begin
          alloc_d = mark_q;
          mark_d  = mark_q + NW'(1);
        end else begin
          res_sts_d = cht_pkg::STS_FULL;
        end
      cht_pkg::ST_POP:
        free_d = r_link;
      cht_pkg::ST_INS: begin
        nd_we       = 1'b1;
        nd_waddr    = alloc_q[NA-1:0];
        nd_wdata    = {key_q, val_q, head_q};
        bh_we       = 1'b1;
        bh_wdata    = alloc_q;
        count_d     = count_q + NW'(1);
        res_found_d = 1'b1;
        res_data_d  = val_q;
      end
      cht_pkg::ST_DONE:
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          data_d      = 32'(res_data_q);
          status_d    = res_sts_q;
          ecount_d    = count_q;
          clr_pend_d  = 1'b0;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cht_pkg::ST_INIT;
      free_q      <= NIL;
      mark_q      <= '0;
      count_q     <= '0;
      sweep_q     <= '0;
      clr_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      mark_q      <= mark_d;
      count_q     <= count_d;
      sweep_q     <= sweep_d;
      clr_pend_q  <= clr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;  key_q <= key_d;  val_q <= val_d;  bkt_q <= bkt_d;
    head_q <= head_d; cur_q <= cur_d; prev_q <= prev_d; alloc_q <= alloc_d;
    pkey_q <= pkey_d; pval_q <= pval_d;
    res_found_q <= res_found_d; res_data_q <= res_data_d; res_sts_q <= res_sts_d;
    found_q <= found_d; data_q <= data_d; status_q <= status_d; ecount_q <= ecount_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign data_o        = data_q;
  assign status_o      = status_q;
  assign entry_count_o = ecount_q;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mark_q) else $error("entry count exceeds nodes handed out");
  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= NIL) else $error("bump mark beyond pool");
  a_ins_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cht_pkg::ST_INS |-> alloc_q < NIL) else $error("insert into null node");
  a_free_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cht_pkg::ST_FREE |-> count_q != '0) else $error("unlink from empty table");
`endif

endmodule
`default_nettype wire
